// ===== rtl/core/mbf_pkg.sv =====
// Shared types, constants and widths of the box mean filter.
`default_nettype none
package mbf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 15;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int PIX_W  = 8;
   localparam int COL_W  = 12;  // column index, up to 4096 pixels per row
   localparam int ROW_W  = 13;  // row index and row/column counts up to 4096
   localparam int SLOT_W = 5;   // line store row slot, up to 32 rows
   localparam int POS_W  = 24;  // raster position within a frame
   localparam int LAG_W  = 16;
   localparam int HALF_W = 3;
   localparam int WIN_W  = 4;
   localparam int DIV_W  = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0]  width;
      logic [ROW_W-1:0]  height;
      logic [HALF_W-1:0] half;
      logic [DIV_W-1:0]  divisor;
      logic [LAG_W-1:0]  lag;
   } cfg_type;

   typedef struct packed {
      logic              write_en;
      logic [SLOT_W-1:0] wr_slot;
      logic [COL_W-1:0]  wr_col;
      logic [PIX_W-1:0]  pixel;
      logic              emit;
      logic              interior;
      logic              frame_end;
      logic [SLOT_W-1:0] out_slot;
      logic [COL_W-1:0]  out_col;
   } task_type;

endpackage
`default_nettype wire

// ===== rtl/core/mbf_front.sv =====
// Front end: tracks input and output raster positions and classifies each word.
`default_nettype none
module mbf_front #(
   parameter int MAX_WINDOW = mbf_pkg::MAX_WINDOW_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  mbf_pkg::cfg_type           cfg,
   input  wire                        restart,
   input  wire                        accept,
   input  wire                        opcode,
   input  wire [mbf_pkg::PIX_W-1:0]   pixel_in,
   output logic                       q_push,
   output mbf_pkg::task_type          q_task
);
   localparam int ROWS = 2 * (MAX_WINDOW / 2) + 1;

   logic [mbf_pkg::COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [mbf_pkg::ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [mbf_pkg::SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [mbf_pkg::POS_W-1:0]  in_pos_ff, in_pos_in;
   logic                       complete, out_last;
   logic [mbf_pkg::ROW_W:0]    m_plus_s, n_plus_s;

   always_comb begin
      complete = in_row_ff >= cfg.height;
      out_last = (out_row_ff == cfg.height - 1'b1) &&
                 ({1'b0, out_col_ff} == cfg.width - 1'b1);
      m_plus_s = {1'b0, out_row_ff} + (mbf_pkg::ROW_W+1)'(cfg.half);
      n_plus_s = {2'b0, out_col_ff} + (mbf_pkg::ROW_W+1)'(cfg.half);

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      in_pos_in   = in_pos_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;

      q_task           = '0;
      q_task.wr_slot   = in_slot_ff;
      q_task.wr_col    = in_col_ff;
      q_task.pixel     = pixel_in;
      q_task.out_slot  = out_slot_ff;
      q_task.out_col   = out_col_ff;
      q_task.frame_end = out_last;
      q_task.interior  = (out_row_ff >= mbf_pkg::ROW_W'(cfg.half)) &&
                         (m_plus_s < {1'b0, cfg.height}) &&
                         (out_col_ff >= mbf_pkg::COL_W'(cfg.half)) &&
                         (n_plus_s < {1'b0, cfg.width});

      if (accept) begin
         if (opcode == mbf_pkg::OP_PIXEL) begin
            if (!complete) begin
               q_task.write_en = 1'b1;
               q_task.emit     = in_pos_ff >= mbf_pkg::POS_W'(cfg.lag);
               in_pos_in       = in_pos_ff + 1'b1;
               // advance input column, wrap into the next row
               if ({1'b0, in_col_ff} + 1'b1 == cfg.width) begin
                  in_col_in  = '0;
                  in_row_in  = in_row_ff + 1'b1;
                  in_slot_in = (in_slot_ff == mbf_pkg::SLOT_W'(ROWS - 1)) ? '0
                                                                 : in_slot_ff + 1'b1;
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end
         end else begin
            q_task.emit = complete;
         end

         if (q_task.emit) begin
            if (out_last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               in_slot_in  = '0;
               in_pos_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
            end else if ({1'b0, out_col_ff} + 1'b1 == cfg.width) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + 1'b1;
               out_slot_in = (out_slot_ff == mbf_pkg::SLOT_W'(ROWS - 1)) ? '0
                                                                : out_slot_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end

      q_push = accept && (q_task.write_en || q_task.emit);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         in_pos_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         in_pos_ff   <= in_pos_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/mbf_queue.sv =====
// Two-entry task queue between front and back end.
`default_nettype none
module mbf_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  mbf_pkg::task_type  task_in,
   output logic               full,
   input  wire                pop,
   output logic               empty,
   output mbf_pkg::task_type  task_out
);
   mbf_pkg::task_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign task_out = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= task_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/mbf_back.sv =====
// Back end: line store, window accumulation, serial divider and result register.
`default_nettype none
module mbf_back #(
   parameter int MAX_WIDTH  = mbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = mbf_pkg::MAX_WINDOW_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  mbf_pkg::cfg_type          cfg,
   input  wire                       q_empty,
   input  mbf_pkg::task_type         q_task,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire                       rsp_pop,
   output logic [mbf_pkg::PIX_W-1:0] rsp_pixel_out,
   output logic                      rsp_was_filtered,
   output logic                      rsp_frame_end
);
   localparam int ROWS   = 2 * (MAX_WINDOW / 2) + 1;
   localparam int DEPTH  = ROWS * MAX_WIDTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int SUM_W  = $clog2(ROWS * ROWS * 255 + 1);
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int SW     = mbf_pkg::SLOT_W;
   localparam int DW     = mbf_pkg::DIV_W;

   typedef enum logic [2:0] {ST_IDLE, ST_ADDR, ST_ACC, ST_DIV, ST_OUT} state_type;

   logic [mbf_pkg::PIX_W-1:0] mem [DEPTH];
   logic [mbf_pkg::PIX_W-1:0] rd_data_ff;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic                      wr_en;

   state_type                 state_ff, state_in;
   logic [SW-1:0]             row_ff, row_in, i_ff, i_in, j_ff, j_in, last_ff, last_in;
   logic [mbf_pkg::COL_W-1:0] col_ff, col_in, col0_ff, col0_in;
   logic                      interior_ff, interior_in, fend_ff, fend_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [DW:0]               rem_ff, rem_in, rem_shift;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic                      valid_ff, valid_in;
   logic [mbf_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic                      filt_ff, filt_in, oend_ff, oend_in;

   assign wr_addr = AW'(int'(q_task.wr_slot) * MAX_WIDTH + int'(q_task.wr_col));
   assign rd_addr = AW'(int'(row_ff) * MAX_WIDTH + int'(col_ff));
   assign wr_en   = q_pop && q_task.write_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_task.pixel;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_pixel_out    = pix_ff;
   assign rsp_was_filtered = filt_ff;
   assign rsp_frame_end    = oend_ff;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      col0_in     = col0_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      last_in     = last_ff;
      interior_in = interior_ff;
      fend_in     = fend_ff;
      sum_in      = sum_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      pix_in      = pix_ff;
      filt_in     = filt_ff;
      oend_in     = oend_ff;
      valid_in    = valid_ff && !rsp_pop;
      q_pop       = (state_ff == ST_IDLE) && !q_empty;
      rem_shift   = {rem_ff[DW-1:0], sum_ff[SUM_W-1]};

      case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_task.emit) begin
               interior_in = q_task.interior;
               fend_in     = q_task.frame_end;
               sum_in      = '0;
               i_in        = '0;
               j_in        = '0;
               if (q_task.interior) begin
                  // start at the window's top-left corner, rows wrap in the store
                  row_in  = (q_task.out_slot >= SW'(cfg.half))
                            ? q_task.out_slot - SW'(cfg.half)
                            : q_task.out_slot + SW'(ROWS) - SW'(cfg.half);
                  col_in  = q_task.out_col - mbf_pkg::COL_W'(cfg.half);
                  col0_in = q_task.out_col - mbf_pkg::COL_W'(cfg.half);
                  last_in = SW'({cfg.half, 1'b0});
               end else begin
                  row_in  = q_task.out_slot;
                  col_in  = q_task.out_col;
                  col0_in = q_task.out_col;
                  last_in = '0;
               end
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = sum_ff + SUM_W'(rd_data_ff);
            state_in = ST_ADDR;
            if (j_ff == last_ff) begin
               j_in   = '0;
               col_in = col0_ff;
               if (i_ff == last_ff) begin
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = interior_ff ? ST_DIV : ST_OUT;
               end else begin
                  i_in   = i_ff + 1'b1;
                  row_in = (row_ff == SW'(ROWS - 1)) ? '0 : row_ff + 1'b1;
               end
            end else begin
               j_in   = j_ff + 1'b1;
               col_in = col_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // one quotient bit a cycle, quotient shifts into the sum register
            if (rem_shift >= {1'b0, cfg.divisor}) begin
               rem_in = rem_shift - {1'b0, cfg.divisor};
               sum_in = {sum_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               sum_in = {sum_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(SUM_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_pop) begin
               valid_in = 1'b1;
               pix_in   = sum_ff[mbf_pkg::PIX_W-1:0];
               filt_in  = interior_ff;
               oend_in  = fend_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      col0_ff     <= col0_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      last_ff     <= last_in;
      interior_ff <= interior_in;
      fend_ff     <= fend_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      pix_ff      <= pix_in;
      filt_ff     <= filt_in;
      oend_ff     <= oend_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/box_mean_filter.sv =====
// Top level of the streaming box mean filter: register file and block wiring.
`default_nettype none
// Streaming box mean filter for 8-bit grayscale frames in raster order. Push
// one word per pixel (opcode pixel) and, after the last pixel of a frame, flush
// words until the word with frame_end set pops out; each output position lags
// its input by half a window down and right. Interior outputs are the window
// sum divided by w*w, low 8 bits kept; border outputs pass the pixel through.
// Timing: the front end takes a word per cycle while its two-entry queue has
// room. The back end pops a task only when idle and finishes it first: a pixel
// with no output is just stored, a border output reads one pixel, an interior
// one its (2s+1)^2 pixels (s = w/2) via the single read port of the line
// store, then divides the SUM_W-bit sum one quotient bit a cycle (SUM_W = 16
// at the default window limit). The line store holds 2*(MAX_WINDOW/2)+1 rows
// of MAX_WIDTH pixels, needs no clearing pass, and only ever reads pixels of
// the current frame. A CSR write to any listed register restarts the frame;
// write only while the block is idle. Out-of-range settings clamp: zero acts
// as one, large ones the maximum; a write keeps 11 width bits, 4 window bits.
module box_mean_filter #(
   parameter int MAX_WIDTH  = mbf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = mbf_pkg::MAX_WINDOW_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_push,
   output logic                            req_full,
   input  wire                             req_opcode,
   input  wire [mbf_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                            rsp_empty,
   input  wire                             rsp_pop,
   output logic [mbf_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic                            rsp_was_filtered,
   output logic                            rsp_frame_end,
   input  wire                             csr_we,
   input  wire [mbf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [mbf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   logic [10:0]                    width_ff;
   logic [12:0]                    height_ff;
   logic [mbf_pkg::WIN_W-1:0]      window_ff;
   logic [mbf_pkg::WIN_W-1:0]      win_eff;
   mbf_pkg::cfg_type               cfg;
   logic                           restart, accept, q_push, q_full, q_pop, q_empty;
   mbf_pkg::task_type              push_task, pop_task;

   // hold the raw registers; a listed write also restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd512;
         height_ff <= 13'd512;
         window_ff <= 4'd5;
      end else if (csr_we) begin
         case (csr_index)
            mbf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[10:0];
            mbf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[12:0];
            mbf_pkg::CSR_WINDOW_SIZE:  window_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_we && (csr_index == mbf_pkg::CSR_IMAGE_WIDTH ||
                               csr_index == mbf_pkg::CSR_IMAGE_HEIGHT ||
                               csr_index == mbf_pkg::CSR_WINDOW_SIZE);

   // clamp settings into their working ranges
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = mbf_pkg::ROW_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = mbf_pkg::ROW_W'(MAX_WIDTH);
      end else begin
         cfg.width = mbf_pkg::ROW_W'(width_ff);
      end
      if (height_ff == '0) begin
         cfg.height = mbf_pkg::ROW_W'(1);
      end else if (int'(height_ff) > mbf_pkg::HEIGHT_LIMIT) begin
         cfg.height = mbf_pkg::ROW_W'(mbf_pkg::HEIGHT_LIMIT);
      end else begin
         cfg.height = height_ff;
      end
      if (window_ff == '0) begin
         win_eff = mbf_pkg::WIN_W'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         win_eff = mbf_pkg::WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = window_ff;
      end
      cfg.half    = mbf_pkg::HALF_W'(win_eff >> 1);
      cfg.divisor = {4'b0, win_eff} * {4'b0, win_eff};
      cfg.lag     = mbf_pkg::LAG_W'(cfg.half) * mbf_pkg::LAG_W'(cfg.width) +
                    mbf_pkg::LAG_W'(cfg.half);
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   mbf_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .restart  (restart),
      .accept   (accept),
      .opcode   (req_opcode),
      .pixel_in (req_pixel_in),
      .q_push   (q_push),
      .q_task   (push_task)
   );

   mbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .task_in  (push_task),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .task_out (pop_task)
   );

   mbf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .q_task           (pop_task),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_was_filtered (rsp_was_filtered),
      .rsp_frame_end    (rsp_frame_end)
   );
endmodule
`default_nettype wire
